// ===== design/mtat_pkg.sv =====
// Shared types and constants for the multi-turn angle tracker.
package mtat_pkg;

  localparam int CPR_W = 17;
  localparam int OFFSET_W = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_CPR    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 1'b1;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

endpackage

// ===== design/mtat_in_if.sv =====
// Input channel carrying one raw encoder count per transfer.
interface mtat_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_count;

  modport source (output valid, output raw_count, input ready);
  modport sink (input valid, input raw_count, output ready);
endinterface

// ===== design/mtat_out_if.sv =====
// Result channel carrying the angle outputs of one sample per transfer.
interface mtat_out_if;
  logic               valid;
  logic               ready;
  logic        [24:0] raw_deg;
  logic        [24:0] turn_deg;
  logic signed [15:0] turns;
  logic signed [40:0] abs_deg;
  logic               range_error;

  modport source (output valid, output raw_deg, output turn_deg, output turns,
                  output abs_deg, output range_error, input ready);
  modport sink (input valid, input raw_deg, input turn_deg, input turns,
                input abs_deg, input range_error, output ready);
endinterface

// ===== design/mtat_cfg_if.sv =====
// Configuration write channel carrying a register index and write data.
interface mtat_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [16:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/mtat_div.sv =====
// Shared restoring divide step unit with remainder and shifting dividend registers.
module mtat_div #(
  parameter int DVD_W = 25
) (
  input  logic                         clk,
  input  mtat_pkg::div_ctl_t           ctl,
  input  logic [mtat_pkg::CPR_W-1:0]   cpr,
  input  logic [mtat_pkg::CPR_W-1:0]   load_rem,
  input  logic [DVD_W-1:0]             load_dvd,
  output logic [mtat_pkg::CPR_W-1:0]   rem,
  output logic [DVD_W-1:0]             dvd
);
  import mtat_pkg::*;

  logic [CPR_W-1:0] rem_r;
  logic [CPR_W-1:0] rem_nxt;
  logic [DVD_W-1:0] dvd_r;
  logic [DVD_W-1:0] dvd_nxt;
  logic [CPR_W:0]   trial;
  logic [CPR_W:0]   trial_sub;
  logic             fits;

  always_comb begin
    trial     = {rem_r, dvd_r[DVD_W-1]};
    trial_sub = trial - {1'b0, cpr};
    fits      = (trial >= {1'b0, cpr});
    rem_nxt   = rem_r;
    dvd_nxt   = dvd_r;
    if (ctl.load) begin
      rem_nxt = load_rem;
      dvd_nxt = load_dvd;
    end else if (ctl.step) begin
      rem_nxt = fits ? trial_sub[CPR_W-1:0] : trial[CPR_W-1:0];
      dvd_nxt = {dvd_r[DVD_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
  end

  assign rem = rem_r;
  assign dvd = dvd_r;

endmodule

// ===== design/multi_turn_angle_tracker_core.sv =====
// Top level of the multi-turn angle tracker: sequencer, state and output register.
//
// One raw encoder count enters per transfer on in_ch; one result leaves per
// transfer on out_ch. cfg_ch writes counts_per_rev (index 0) and zero_offset
// (index 1); it is always ready and should be used only while the block is idle.
// A sample first checks the count against counts_per_rev, reduces the offset
// modulo counts_per_rev when it is out of range, forms the offset count, and
// then divides count*360 and offset count*360 by counts_per_rev in the shared
// one-bit-per-cycle divide unit. The result is registered in the done step
// after the check, the optional offset reduction, the offset count, both
// divides and the turn update; a count out of range goes from the check
// straight to the done step. in_ch is ready only while the sequencer is idle,
// so a new sample can be taken once a result is registered and the sequencer
// is back in idle, even while that result still waits on out_ch. A stalled
// receiver holds the result in the output register and the next finished
// sample waits until that register is free. Reset clears the turn counter and
// the previous angle and restores counts_per_rev to 16384 and zero_offset to 0.
module multi_turn_angle_tracker_core #(
  parameter int FRAC_BITS  = 16,
  parameter int TURN_BITS  = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  mtat_in_if.sink     in_ch,
  mtat_out_if.source  out_ch,
  mtat_cfg_if.sink    cfg_ch
);
  import mtat_pkg::*;

  localparam int AW     = 9 + FRAC_BITS;
  localparam int DVD_W  = (AW > COUNT_BITS) ? AW : COUNT_BITS;
  localparam int CNT_W  = $clog2(DVD_W + 1);
  localparam int PROD_W = CPR_W + 9;

  localparam logic [AW-1:0] DEG_HALF = AW'(180) << FRAC_BITS;
  localparam logic signed [40:0] DEG_FULL_ABS = 41'(360) << FRAC_BITS;
  localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
  localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK  = 4'd1;
  localparam logic [3:0] S_MOD  = 4'd2;
  localparam logic [3:0] S_DIFF = 4'd3;
  localparam logic [3:0] S_DIVR = 4'd4;
  localparam logic [3:0] S_RAWQ = 4'd5;
  localparam logic [3:0] S_DIVA = 4'd6;
  localparam logic [3:0] S_TURN = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]                  state_r, state_nxt;
  logic [COUNT_BITS-1:0]       count_r, count_nxt;
  logic [CPR_W-1:0]            diff_r, diff_nxt;
  logic [AW-1:0]               raw_r, raw_nxt;
  logic                        err_r, err_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [AW-1:0]               last_angle_r, last_angle_nxt;
  logic signed [TURN_BITS-1:0] turn_count_r, turn_count_nxt;
  logic [CPR_W-1:0]            cpr_r;
  logic [OFFSET_W-1:0]         offset_r;
  logic                        out_valid_r, out_valid_nxt;
  logic [24:0]                 out_raw_r, out_raw_nxt;
  logic [24:0]                 out_turn_r, out_turn_nxt;
  logic signed [15:0]          out_turns_r, out_turns_nxt;
  logic signed [40:0]          out_abs_r, out_abs_nxt;
  logic                        out_err_r, out_err_nxt;

  div_ctl_t                    div_ctl;
  logic [CPR_W-1:0]            div_load_rem;
  logic [DVD_W-1:0]            div_load_dvd;
  logic [CPR_W-1:0]            div_rem;
  logic [DVD_W-1:0]            div_dvd;

  logic [COUNT_BITS-1:0]       off_cut;
  logic [CPR_W-1:0]            count17;
  logic [CPR_W-1:0]            mul_in;
  logic [PROD_W-1:0]           prod;
  logic [AW-1:0]               prod_lo;
  logic [AW-1:0]               ang;
  logic signed [40:0]          turn_ext;

  mtat_div #(
    .DVD_W (DVD_W)
  ) u_div (
    .clk      (clk),
    .ctl      (div_ctl),
    .cpr      (cpr_r),
    .load_rem (div_load_rem),
    .load_dvd (div_load_dvd),
    .rem      (div_rem),
    .dvd      (div_dvd)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.raw_deg     = out_raw_r;
  assign out_ch.turn_deg    = out_turn_r;
  assign out_ch.turns       = out_turns_r;
  assign out_ch.abs_deg     = out_abs_r;
  assign out_ch.range_error = out_err_r;

  always_comb begin
    off_cut  = COUNT_BITS'(offset_r);
    count17  = CPR_W'(count_r);
    mul_in   = (state_r == S_DIFF) ? count17 : diff_r;
    prod     = PROD_W'(mul_in) * PROD_W'(360);
    prod_lo  = {prod[8:0], {FRAC_BITS{1'b0}}};
    ang      = div_dvd[AW-1:0];
    turn_ext = 41'(turn_count_r);

    state_nxt      = state_r;
    count_nxt      = count_r;
    diff_nxt       = diff_r;
    raw_nxt        = raw_r;
    err_nxt        = err_r;
    cnt_nxt        = cnt_r;
    last_angle_nxt = last_angle_r;
    turn_count_nxt = turn_count_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_raw_nxt    = out_raw_r;
    out_turn_nxt   = out_turn_r;
    out_turns_nxt  = out_turns_r;
    out_abs_nxt    = out_abs_r;
    out_err_nxt    = out_err_r;
    div_ctl        = '0;
    div_load_rem   = '0;
    div_load_dvd   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          count_nxt = COUNT_BITS'(in_ch.raw_count);
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        div_ctl.load = 1'b1;
        if (32'(count_r) >= 32'(cpr_r)) begin
          err_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else if (32'(off_cut) >= 32'(cpr_r)) begin
          err_nxt      = 1'b0;
          div_load_dvd = DVD_W'(off_cut) << (DVD_W - COUNT_BITS);
          cnt_nxt      = CNT_W'(COUNT_BITS - 1);
          state_nxt    = S_MOD;
        end else begin
          err_nxt      = 1'b0;
          div_load_rem = CPR_W'(off_cut);
          state_nxt    = S_DIFF;
        end
      end
      S_MOD: begin
        div_ctl.step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DIFF;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_DIFF: begin
        if (count17 >= div_rem) begin
          diff_nxt = count17 - div_rem;
        end else begin
          diff_nxt = count17 + cpr_r - div_rem;
        end
        div_ctl.load = 1'b1;
        div_load_rem = prod[PROD_W-1:9];
        div_load_dvd = DVD_W'(prod_lo) << (DVD_W - AW);
        cnt_nxt      = CNT_W'(AW - 1);
        state_nxt    = S_DIVR;
      end
      S_DIVR: begin
        div_ctl.step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_RAWQ;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_RAWQ: begin
        raw_nxt      = div_dvd[AW-1:0];
        div_ctl.load = 1'b1;
        div_load_rem = prod[PROD_W-1:9];
        div_load_dvd = DVD_W'(prod_lo) << (DVD_W - AW);
        cnt_nxt      = CNT_W'(AW - 1);
        state_nxt    = S_DIVA;
      end
      S_DIVA: begin
        div_ctl.step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_TURN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_TURN: begin
        if (ang > last_angle_r && (ang - last_angle_r) > DEG_HALF) begin
          if (turn_count_r != TURN_MIN) begin
            turn_count_nxt = turn_count_r - 1'b1;
          end
        end else if (last_angle_r > ang && (last_angle_r - ang) > DEG_HALF) begin
          if (turn_count_r != TURN_MAX) begin
            turn_count_nxt = turn_count_r + 1'b1;
          end
        end
        last_angle_nxt = ang;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_raw_nxt   = err_r ? 25'd0 : 25'(raw_r);
          out_turn_nxt  = 25'(last_angle_r);
          out_turns_nxt = 16'(turn_count_r);
          out_abs_nxt   = 41'(turn_ext * DEG_FULL_ABS) + 41'(last_angle_r);
          out_err_nxt   = err_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      last_angle_r <= '0;
      turn_count_r <= '0;
      cpr_r        <= CPR_W'(16384);
      offset_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      last_angle_r <= last_angle_nxt;
      turn_count_r <= turn_count_nxt;
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          REG_CPR:    cpr_r    <= cfg_ch.data;
          REG_OFFSET: offset_r <= cfg_ch.data[OFFSET_W-1:0];
          default:    cpr_r    <= cpr_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    count_r     <= count_nxt;
    diff_r      <= diff_nxt;
    raw_r       <= raw_nxt;
    err_r       <= err_nxt;
    cnt_r       <= cnt_nxt;
    out_raw_r   <= out_raw_nxt;
    out_turn_r  <= out_turn_nxt;
    out_turns_r <= out_turns_nxt;
    out_abs_r   <= out_abs_nxt;
    out_err_r   <= out_err_nxt;
  end

  a_turn_only_in_update: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_TURN) |=> $stable(turn_count_r))
    else $error("turn counter changed outside the update step");

  a_turn_step_size: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TURN) |=> (turn_count_r == $past(turn_count_r) ||
                             turn_count_r == $past(turn_count_r) + 1'b1 ||
                             turn_count_r == $past(turn_count_r) - 1'b1))
    else $error("turn counter moved by more than one revolution");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result presented without passing the done step");

  a_accept_starts_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == S_CHK))
    else $error("input transfer did not start a range check");

endmodule
